@@ hdl/rht_pkg.sv @@
// Shared widths, codes and control structs for the rectangle hit table.
package rht_pkg;

    localparam int DEF_TABLE_SLOTS = 16;
    localparam int DEF_ID_BITS     = 16;

    localparam int MODE_W    = 2;
    localparam int COORD_W   = 16;
    localparam int SIZE_W    = 15;
    localparam int TID_W     = 16;
    localparam int STATUS_W  = 2;
    localparam int RID_W     = 16;
    localparam int CNT_OUT_W = 5;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_mode MODE_ADD    = 2'd0;
    localparam t_mode MODE_REMOVE = 2'd1;
    localparam t_mode MODE_PROBE  = 2'd2;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_MISS = 2'd1;
    localparam t_status ST_FULL = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic reduce;
        logic commit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_probe;
    } t_dp_stat;

endpackage

@@ hdl/rht_in_if.sv @@
// Request channel: one command transaction per item.
interface rht_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [rht_pkg::MODE_W-1:0]           mode;
    logic signed [rht_pkg::COORD_W-1:0]   box_x;
    logic signed [rht_pkg::COORD_W-1:0]   box_y;
    logic [rht_pkg::SIZE_W-1:0]           box_w;
    logic [rht_pkg::SIZE_W-1:0]           box_h;
    logic [rht_pkg::TID_W-1:0]            target_id;
    logic signed [rht_pkg::COORD_W-1:0]   point_x;
    logic signed [rht_pkg::COORD_W-1:0]   point_y;

    modport source (
        output valid, mode, box_x, box_y, box_w, box_h, target_id, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, mode, box_x, box_y, box_w, box_h, target_id, point_x, point_y,
        output ready
    );
endinterface

@@ hdl/rht_out_if.sv @@
// Response channel: one result transaction per item.
interface rht_out_if;
    logic                            valid;
    logic                            ready;
    logic [rht_pkg::STATUS_W-1:0]    status;
    logic [rht_pkg::RID_W-1:0]       result_id;
    logic [rht_pkg::CNT_OUT_W-1:0]   entry_count;

    modport source (
        output valid, status, result_id, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, result_id, entry_count,
        output ready
    );
endinterface

@@ hdl/rht_ctrl.sv @@
// Sequencer for the hit table: accept, evaluate, reduce, commit.
module rht_ctrl #(
    parameter int TABLE_SLOTS = rht_pkg::DEF_TABLE_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rht_pkg::t_dp_cmd  o_cmd,
    input  rht_pkg::t_dp_stat i_stat
);

    localparam int LVL   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int LVL_W = $clog2(LVL + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EVAL   = 4'b0010,
        S_REDUCE = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic               r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_lvl      = '0;
                n_state    = i_stat.is_probe ? S_REDUCE : S_FINISH;
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
                n_lvl        = LVL_W'(r_lvl + 1'b1);
                if (r_lvl == LVL_W'(LVL - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lvl       <= n_lvl;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("commit did not raise response valid");

    a_reduce_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REDUCE) |-> (r_lvl < LVL_W'(LVL)))
        else $error("reduction ran past the last tree level");

endmodule

@@ hdl/rht_dp.sv @@
// Slot table, parallel compare lanes, min-id reduction and result register.
module rht_dp #(
    parameter int TABLE_SLOTS = rht_pkg::DEF_TABLE_SLOTS,
    parameter int ID_BITS     = rht_pkg::DEF_ID_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rht_pkg::t_dp_cmd                    i_cmd,
    output rht_pkg::t_dp_stat                   o_stat,
    input  logic [rht_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [rht_pkg::COORD_W-1:0]  i_box_x,
    input  logic signed [rht_pkg::COORD_W-1:0]  i_box_y,
    input  logic [rht_pkg::SIZE_W-1:0]          i_box_w,
    input  logic [rht_pkg::SIZE_W-1:0]          i_box_h,
    input  logic [rht_pkg::TID_W-1:0]           i_target_id,
    input  logic signed [rht_pkg::COORD_W-1:0]  i_point_x,
    input  logic signed [rht_pkg::COORD_W-1:0]  i_point_y,
    output logic [rht_pkg::STATUS_W-1:0]        o_status,
    output logic [rht_pkg::RID_W-1:0]           o_result_id,
    output logic [rht_pkg::CNT_OUT_W-1:0]       o_entry_count
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int LVL   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int P     = 1 << LVL;
    localparam int CMP_W = (ID_BITS > rht_pkg::TID_W) ? ID_BITS : rht_pkg::TID_W;
    localparam int CW    = rht_pkg::COORD_W;
    localparam int SW    = rht_pkg::SIZE_W;

    // latched request
    rht_pkg::t_mode            r_mode;
    logic signed [CW-1:0]      r_box_x, r_box_y, r_px, r_py;
    logic [SW-1:0]             r_box_w, r_box_h;
    logic [rht_pkg::TID_W-1:0] r_target;

    // slot table
    logic [TABLE_SLOTS-1:0]    r_slot_valid, n_slot_valid;
    logic [ID_BITS-1:0]        r_slot_id     [TABLE_SLOTS];
    logic signed [CW-1:0]      r_slot_left   [TABLE_SLOTS];
    logic signed [CW-1:0]      r_slot_top    [TABLE_SLOTS];
    logic [SW-1:0]             r_slot_width  [TABLE_SLOTS];
    logic [SW-1:0]             r_slot_height [TABLE_SLOTS];
    logic [ID_BITS-1:0]        r_last_id, n_last_id;
    logic [CNT_W-1:0]          r_count, n_count;

    // evaluation results
    logic [TABLE_SLOTS-1:0]    w_hit, w_match, r_match;
    logic                      w_free_found, r_free_found;
    logic [IDX_W-1:0]          w_free_idx, r_free_idx;

    // min-id reduction tree, folded in place one level per cycle
    logic                      r_cand_vld [P];
    logic [ID_BITS-1:0]        r_cand_id  [P];
    logic                      n_cand_vld [P];
    logic [ID_BITS-1:0]        n_cand_id  [P];

    // result register
    rht_pkg::t_status          r_out_status, n_out_status;
    logic [ID_BITS-1:0]        r_out_rid, n_out_rid;
    logic [CNT_W-1:0]          r_out_cnt;
    logic                      w_slot_we;

    // strict lo < p < lo + len, exact in CW+1 bits
    function automatic logic in_span(input logic signed [CW-1:0] p,
                                     input logic signed [CW-1:0] lo,
                                     input logic [SW-1:0] len);
        logic signed [CW:0] p_e, lo_e, hi_e;
        p_e  = (CW+1)'(p);
        lo_e = (CW+1)'(lo);
        hi_e = lo_e + $signed((CW+1)'(len));
        return (p_e > lo_e) && (p_e < hi_e);
    endfunction

    assign o_stat.is_probe = (r_mode == rht_pkg::MODE_PROBE);

    always_comb begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            w_hit[i]   = r_slot_valid[i]
                      && in_span(r_px, r_slot_left[i], r_slot_width[i])
                      && in_span(r_py, r_slot_top[i], r_slot_height[i]);
            w_match[i] = r_slot_valid[i]
                      && (CMP_W'(r_slot_id[i]) == CMP_W'(r_target));
        end
    end

    // lowest free slot
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (!r_slot_valid[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < P; k++) begin
            n_cand_vld[k] = r_cand_vld[k];
            n_cand_id[k]  = r_cand_id[k];
        end
        if (i_cmd.eval) begin
            for (int k = 0; k < P; k++) begin
                n_cand_vld[k] = 1'b0;
            end
            for (int k = 0; k < TABLE_SLOTS; k++) begin
                n_cand_vld[k] = w_hit[k];
                n_cand_id[k]  = r_slot_id[k];
            end
        end else if (i_cmd.reduce) begin
            for (int k = 0; k < P / 2; k++) begin
                if (r_cand_vld[2*k] &&
                    (!r_cand_vld[2*k+1] || r_cand_id[2*k] < r_cand_id[2*k+1])) begin
                    n_cand_vld[k] = 1'b1;
                    n_cand_id[k]  = r_cand_id[2*k];
                end else begin
                    n_cand_vld[k] = r_cand_vld[2*k+1];
                    n_cand_id[k]  = r_cand_id[2*k+1];
                end
            end
        end
    end

    // table update and response for the item at hand
    always_comb begin
        n_slot_valid = r_slot_valid;
        n_last_id    = r_last_id;
        n_count      = r_count;
        n_out_status = rht_pkg::ST_MISS;
        n_out_rid    = '0;
        w_slot_we    = 1'b0;
        case (r_mode)
            rht_pkg::MODE_ADD: begin
                if (r_free_found && !(&r_last_id)) begin
                    w_slot_we                = 1'b1;
                    n_slot_valid[r_free_idx] = 1'b1;
                    n_last_id                = ID_BITS'(r_last_id + 1'b1);
                    n_count                  = CNT_W'(r_count + 1'b1);
                    n_out_status             = rht_pkg::ST_OK;
                    n_out_rid                = n_last_id;
                end else begin
                    n_out_status = rht_pkg::ST_FULL;
                end
            end
            rht_pkg::MODE_REMOVE: begin
                if (|r_match) begin
                    n_slot_valid = r_slot_valid & ~r_match;
                    n_count      = CNT_W'(r_count - 1'b1);
                    n_out_status = rht_pkg::ST_OK;
                end
            end
            rht_pkg::MODE_PROBE: begin
                if (r_cand_vld[0]) begin
                    n_out_status = rht_pkg::ST_OK;
                    n_out_rid    = r_cand_id[0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_last_id    <= '0;
            r_count      <= '0;
        end else if (i_cmd.commit) begin
            r_slot_valid <= n_slot_valid;
            r_last_id    <= n_last_id;
            r_count      <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_box_x  <= i_box_x;
            r_box_y  <= i_box_y;
            r_box_w  <= i_box_w;
            r_box_h  <= i_box_h;
            r_target <= i_target_id;
            r_px     <= i_point_x;
            r_py     <= i_point_y;
        end
        if (i_cmd.eval) begin
            r_match      <= w_match;
            r_free_found <= w_free_found;
            r_free_idx   <= w_free_idx;
        end
        for (int k = 0; k < P; k++) begin
            r_cand_vld[k] <= n_cand_vld[k];
            r_cand_id[k]  <= n_cand_id[k];
        end
        if (w_slot_we && i_cmd.commit) begin
            r_slot_id[r_free_idx]     <= n_last_id;
            r_slot_left[r_free_idx]   <= r_box_x;
            r_slot_top[r_free_idx]    <= r_box_y;
            r_slot_width[r_free_idx]  <= r_box_w;
            r_slot_height[r_free_idx] <= r_box_h;
        end
        if (i_cmd.commit) begin
            r_out_status <= n_out_status;
            r_out_rid    <= n_out_rid;
            r_out_cnt    <= n_count;
        end
    end

    assign o_status      = r_out_status;
    assign o_result_id   = rht_pkg::RID_W'(r_out_rid);
    assign o_entry_count = rht_pkg::CNT_OUT_W'(r_out_cnt);

    a_count_tracks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) == $countones(r_slot_valid))
        else $error("box count disagrees with valid slots");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= TABLE_SLOTS)
        else $error("box count above table size");

    a_id_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_last_id >= $past(r_last_id)))
        else $error("id counter went backwards");

endmodule

@@ hdl/rectangle_hit_table.sv @@
// Top level of the rectangle hit table: channel glue, sequencer and datapath.
//
// Usage:
//   i_req carries one command transaction: mode 0 adds a box (box_x, box_y,
//   box_w, box_h), mode 1 removes the box whose id is target_id, mode 2 probes
//   the point (point_x, point_y). Every request yields exactly one response
//   transaction on o_rsp with status, result_id and the entry count after it.
//   Ids come from a counter that starts at 1 and are never reused; a probe
//   answers with the lowest id among the boxes that strictly contain the point.
// Timing:
//   One item is evaluated at a time. Add, remove and unused modes pass through
//   accept, evaluate and commit; commit makes the response valid and brings
//   i_req.ready back together. A probe adds a reduce step for each level of
//   the min-id tree, which folds one level per cycle.
// Reset:
//   Synchronous, active low. Clears all slot valid bits, the id counter and
//   the count; slot contents are not cleared. No clearing pass is needed.
// Backpressure:
//   A response waits in its register while o_rsp.ready is low; the next
//   request is still accepted and evaluated, and only its commit waits.
module rectangle_hit_table #(
    parameter int TABLE_SLOTS = rht_pkg::DEF_TABLE_SLOTS,
    parameter int ID_BITS     = rht_pkg::DEF_ID_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rht_in_if.sink    i_req,
    rht_out_if.source o_rsp
);

    rht_pkg::t_dp_cmd  w_cmd;
    rht_pkg::t_dp_stat w_stat;

    // sequencer: owns the handshakes and the response valid flag
    rht_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // datapath: slot table, compare lanes, reduction and response payload
    rht_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_mode        (i_req.mode),
        .i_box_x       (i_req.box_x),
        .i_box_y       (i_req.box_y),
        .i_box_w       (i_req.box_w),
        .i_box_h       (i_req.box_h),
        .i_target_id   (i_req.target_id),
        .i_point_x     (i_req.point_x),
        .i_point_y     (i_req.point_y),
        .o_status      (o_rsp.status),
        .o_result_id   (o_rsp.result_id),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule

@@ tb/tb.sv @@
// Testbench for the rectangle hit table: queued stimulus, table predictor and response checks.
`timescale 1ns / 1ps

module tb;

    localparam int            SLOTS       = rht_pkg::DEF_TABLE_SLOTS;
    localparam int unsigned   ID_LIMIT    = (1 << rht_pkg::DEF_ID_BITS) - 1;
    localparam rht_pkg::t_mode MODE_UNUSED = 2'd3;
    localparam int            TAIL_CYCLES = 20;
    localparam int            PRINT_CAP   = 50;

    typedef struct packed {
        rht_pkg::t_mode                     mode;
        logic signed [rht_pkg::COORD_W-1:0] box_x;
        logic signed [rht_pkg::COORD_W-1:0] box_y;
        logic [rht_pkg::SIZE_W-1:0]         box_w;
        logic [rht_pkg::SIZE_W-1:0]         box_h;
        logic [rht_pkg::TID_W-1:0]          target_id;
        logic signed [rht_pkg::COORD_W-1:0] point_x;
        logic signed [rht_pkg::COORD_W-1:0] point_y;
    } t_cmd;

    typedef struct packed {
        rht_pkg::t_status              status;
        logic [rht_pkg::RID_W-1:0]     result_id;
        logic [rht_pkg::CNT_OUT_W-1:0] entry_count;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    rht_in_if  req_if ();
    rht_out_if rsp_if ();

    rectangle_hit_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Shadow copy of the box table.
    bit          slot_live  [SLOTS];
    int unsigned slot_ident [SLOTS];
    int          slot_left  [SLOTS];
    int          slot_top   [SLOTS];
    int          slot_wid   [SLOTS];
    int          slot_hgt   [SLOTS];
    int unsigned last_ident;
    int          box_total;

    t_cmd pending_cmds [$];
    t_rsp expected_rsp [$];
    t_cmd req_now;

    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int n_items, n_rsp;
    int n_add_ok, n_add_full, n_rm_ok, n_rm_miss, n_hit, n_miss, n_unused;

    // Applies one command to the shadow table and returns the response it yields.
    function automatic t_rsp apply_to_table(t_cmd c);
        t_rsp        r;
        int          free_slot;
        int          px;
        int          py;
        bit          found;
        int unsigned best;
        r.status    = rht_pkg::ST_MISS;
        r.result_id = '0;
        case (c.mode)
            rht_pkg::MODE_ADD: begin
                free_slot = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!slot_live[i] && free_slot < 0) free_slot = i;
                if (free_slot < 0 || last_ident >= ID_LIMIT) begin
                    r.status = rht_pkg::ST_FULL;
                    n_add_full++;
                end else begin
                    last_ident++;
                    slot_live[free_slot]  = 1'b1;
                    slot_ident[free_slot] = last_ident;
                    slot_left[free_slot]  = int'(c.box_x);
                    slot_top[free_slot]   = int'(c.box_y);
                    slot_wid[free_slot]   = int'(c.box_w);
                    slot_hgt[free_slot]   = int'(c.box_h);
                    box_total++;
                    r.status    = rht_pkg::ST_OK;
                    r.result_id = last_ident[rht_pkg::RID_W-1:0];
                    n_add_ok++;
                end
            end
            rht_pkg::MODE_REMOVE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (r.status != rht_pkg::ST_OK && slot_live[i]
                            && slot_ident[i] == int'(c.target_id)) begin
                        slot_live[i] = 1'b0;
                        if (box_total > 0) box_total--;
                        r.status = rht_pkg::ST_OK;
                    end
                end
                if (r.status == rht_pkg::ST_OK) n_rm_ok++;
                else n_rm_miss++;
            end
            rht_pkg::MODE_PROBE: begin
                px    = int'(c.point_x);
                py    = int'(c.point_y);
                found = 1'b0;
                best  = 0;
                // strict containment, edges summed at full width
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_live[i]
                            && px > slot_left[i] && px < slot_left[i] + slot_wid[i]
                            && py > slot_top[i] && py < slot_top[i] + slot_hgt[i]
                            && (!found || slot_ident[i] < best)) begin
                        best  = slot_ident[i];
                        found = 1'b1;
                    end
                end
                if (found) begin
                    r.status    = rht_pkg::ST_OK;
                    r.result_id = best[rht_pkg::RID_W-1:0];
                    n_hit++;
                end else begin
                    n_miss++;
                end
            end
            default: n_unused++;
        endcase
        r.entry_count = box_total[rht_pkg::CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Every field random, so unused fields toggle on every bit.
    function automatic t_cmd noise_cmd();
        t_cmd c;
        c.mode      = rht_pkg::t_mode'($urandom_range(3));
        c.box_x     = rht_pkg::COORD_W'($urandom);
        c.box_y     = rht_pkg::COORD_W'($urandom);
        c.box_w     = rht_pkg::SIZE_W'($urandom);
        c.box_h     = rht_pkg::SIZE_W'($urandom);
        c.target_id = rht_pkg::TID_W'($urandom);
        c.point_x   = rht_pkg::COORD_W'($urandom);
        c.point_y   = rht_pkg::COORD_W'($urandom);
        return c;
    endfunction

    function automatic t_cmd cmd_add(int x, int y, int w, int h);
        t_cmd c;
        c       = noise_cmd();
        c.mode  = rht_pkg::MODE_ADD;
        c.box_x = x[rht_pkg::COORD_W-1:0];
        c.box_y = y[rht_pkg::COORD_W-1:0];
        c.box_w = w[rht_pkg::SIZE_W-1:0];
        c.box_h = h[rht_pkg::SIZE_W-1:0];
        return c;
    endfunction

    function automatic t_cmd cmd_remove(int unsigned id);
        t_cmd c;
        c           = noise_cmd();
        c.mode      = rht_pkg::MODE_REMOVE;
        c.target_id = id[rht_pkg::TID_W-1:0];
        return c;
    endfunction

    function automatic t_cmd cmd_probe(int x, int y);
        t_cmd c;
        c         = noise_cmd();
        c.mode    = rht_pkg::MODE_PROBE;
        c.point_x = x[rht_pkg::COORD_W-1:0];
        c.point_y = y[rht_pkg::COORD_W-1:0];
        return c;
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || req_if.valid || expected_rsp.size() != 0);
    endtask

    // Random traffic in batches of 8, each batch leaning toward filling or draining.
    task automatic run_random(int n);
        t_cmd c;
        int   live_q [$];
        int   add_pct, rm_pct, probe_pct, pick, s, px, py;
        for (int k = 0; k < n; k++) begin
            if (k % 8 == 0) begin
                while (pending_cmds.size() != 0) @(negedge i_clk);
                if ($urandom_range(1)) begin
                    add_pct = 55; rm_pct = 15; probe_pct = 27;
                end else begin
                    add_pct = 20; rm_pct = 45; probe_pct = 32;
                end
            end
            live_q.delete();
            for (int i = 0; i < SLOTS; i++) if (slot_live[i]) live_q.push_back(i);
            pick = $urandom_range(99);
            if (pick < add_pct) begin
                if ($urandom_range(99) < 75) begin
                    c = cmd_add(int'($urandom_range(160)) - 80, int'($urandom_range(160)) - 80,
                                $urandom_range(120), $urandom_range(120));
                    if ($urandom_range(9) == 0) c.box_w = rht_pkg::SIZE_W'($urandom_range(2));
                    if ($urandom_range(9) == 0) c.box_h = rht_pkg::SIZE_W'($urandom_range(2));
                end else begin
                    c      = noise_cmd();
                    c.mode = rht_pkg::MODE_ADD;
                end
            end else if (pick < add_pct + rm_pct) begin
                pick = $urandom_range(99);
                if (pick < 60 && live_q.size() > 0)
                    c = cmd_remove(slot_ident[live_q[$urandom_range(live_q.size() - 1)]]);
                else if (pick < 80)
                    c = cmd_remove($urandom_range(last_ident + 2));
                else begin
                    c      = noise_cmd();
                    c.mode = rht_pkg::MODE_REMOVE;
                end
            end else if (pick < add_pct + rm_pct + probe_pct) begin
                pick = $urandom_range(99);
                if (pick < 65 && live_q.size() > 0) begin
                    // point inside a held box, edges included now and then
                    s  = live_q[$urandom_range(live_q.size() - 1)];
                    px = slot_left[s] + int'($urandom_range(slot_wid[s]));
                    py = slot_top[s] + int'($urandom_range(slot_hgt[s]));
                    if (px > 32767) px = 32767;
                    if (py > 32767) py = 32767;
                    c = cmd_probe(px, py);
                end else if (pick < 85) begin
                    c = cmd_probe(int'($urandom_range(200)) - 100,
                                  int'($urandom_range(200)) - 100);
                end else begin
                    c      = noise_cmd();
                    c.mode = rht_pkg::MODE_PROBE;
                end
            end else begin
                c      = noise_cmd();
                c.mode = MODE_UNUSED;
            end
            pending_cmds.push_back(c);
        end
    endtask

    // Request driver: accepted transactions go through the predictor.
    always @(posedge i_clk) begin
        t_cmd nxt;
        if (!i_rst_n) begin
            req_if.valid     <= 1'b0;
            req_if.mode      <= rht_pkg::MODE_ADD;
            req_if.box_x     <= '0;
            req_if.box_y     <= '0;
            req_if.box_w     <= '0;
            req_if.box_h     <= '0;
            req_if.target_id <= '0;
            req_if.point_x   <= '0;
            req_if.point_y   <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_rsp.push_back(apply_to_table(req_now));
                n_items++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt                = pending_cmds.pop_front();
                    req_now            = nxt;
                    req_if.valid      <= 1'b1;
                    req_if.mode       <= nxt.mode;
                    req_if.box_x      <= nxt.box_x;
                    req_if.box_y      <= nxt.box_y;
                    req_if.box_w      <= nxt.box_w;
                    req_if.box_h      <= nxt.box_h;
                    req_if.target_id  <= nxt.target_id;
                    req_if.point_x    <= nxt.point_x;
                    req_if.point_y    <= nxt.point_y;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor with random backpressure.
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_rsp++;
                if (expected_rsp.size() == 0) begin
                    report_mismatch("unexpected transaction status", 32'(rsp_if.status), 0);
                end else begin
                    want = expected_rsp.pop_front();
                    if (rsp_if.status !== want.status)
                        report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
                    if (rsp_if.result_id !== want.result_id)
                        report_mismatch("result_id", 32'(rsp_if.result_id),
                                        32'(want.result_id));
                    if (rsp_if.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(rsp_if.entry_count),
                                        32'(want.entry_count));
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        t_cmd c;
        errors        = 0;
        n_items       = 0;
        n_rsp         = 0;
        n_add_ok      = 0;
        n_add_full    = 0;
        n_rm_ok       = 0;
        n_rm_miss     = 0;
        n_hit         = 0;
        n_miss        = 0;
        n_unused      = 0;
        last_ident    = 0;
        box_total     = 0;
        for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 68;

        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, odd modes, coordinate extremes, degenerate boxes,
        // strict edges, lowest-id tie break across reused slots.
        c      = noise_cmd();
        c.mode = MODE_UNUSED;
        pending_cmds.push_back(cmd_probe(0, 0));
        pending_cmds.push_back(c);
        pending_cmds.push_back(cmd_remove(0));
        pending_cmds.push_back(cmd_add(-32768, -32768, 32767, 32767));
        pending_cmds.push_back(cmd_add(32767, 32767, 32767, 32767));
        pending_cmds.push_back(cmd_add(0, 0, 1, 1));
        pending_cmds.push_back(cmd_add(-10, -10, 0, 100));
        pending_cmds.push_back(cmd_add(-100, -100, 200, 200));
        pending_cmds.push_back(cmd_probe(-32767, -32767));
        pending_cmds.push_back(cmd_probe(-2, -2));
        pending_cmds.push_back(cmd_probe(-1, -1));
        pending_cmds.push_back(cmd_probe(0, 0));
        pending_cmds.push_back(cmd_probe(99, 99));
        pending_cmds.push_back(cmd_probe(100, 100));
        pending_cmds.push_back(cmd_probe(32767, 32767));
        pending_cmds.push_back(cmd_probe(-5, 0));
        pending_cmds.push_back(cmd_remove(1));
        pending_cmds.push_back(cmd_remove(1));
        pending_cmds.push_back(cmd_add(-50, -50, 100, 100));
        pending_cmds.push_back(cmd_probe(0, 0));
        pending_cmds.push_back(cmd_remove(65535));
        pending_cmds.push_back(cmd_probe(-32768, 32767));
        pending_cmds.push_back(cmd_probe(1, 1));

        run_random(200);
        wait_drained();
        send_idle_pct = 68;
        recv_idle_pct = 7;
        run_random(200);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(150);
        wait_drained();

        // Empty the table, then a few mixed requests on it.
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i]) pending_cmds.push_back(cmd_remove(slot_ident[i]));
        wait_drained();
        pending_cmds.push_back(cmd_add(-20, -20, 40, 40));
        pending_cmds.push_back(cmd_probe(0, 0));
        pending_cmds.push_back(cmd_remove(ID_LIMIT));
        c      = noise_cmd();
        c.mode = MODE_UNUSED;
        pending_cmds.push_back(c);
        pending_cmds.push_back(cmd_add(0, 0, 5, 5));
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests / %0d responses: %0d adds, %0d refused, %0d removes",
                 n_items, n_rsp, n_add_ok, n_add_full, n_rm_ok);
        $display("  %0d removes not found, %0d probe hits, %0d misses, %0d unused, last id %0d",
                 n_rm_miss, n_hit, n_miss, n_unused, last_ident);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #40_000_000;
        $display("timeout with %0d responses outstanding", expected_rsp.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
